// ===== hw/rtl/dprf_pkg.sv =====
// Shared types and constants for the display reply frame parser.
// Holds the frame type codes, event codes and the result record.
// No dependencies.
package dprf_pkg;

   localparam logic [7:0] END_MARK = 8'hFF;

   // Frame type codes (first byte of a frame)
   localparam logic [7:0] TYPE_ERR_CMD     = 8'h00;
   localparam logic [7:0] TYPE_SUCCESS     = 8'h01;
   localparam logic [7:0] TYPE_ERR_COMP    = 8'h02;
   localparam logic [7:0] TYPE_ERR_PAGE    = 8'h03;
   localparam logic [7:0] TYPE_ERR_PIC     = 8'h04;
   localparam logic [7:0] TYPE_ERR_FONT    = 8'h05;
   localparam logic [7:0] TYPE_ERR_BAUD    = 8'h11;
   localparam logic [7:0] TYPE_BUTTON      = 8'h65;
   localparam logic [7:0] TYPE_PAGE        = 8'h66;
   localparam logic [7:0] TYPE_TOUCH_AWAKE = 8'h67;
   localparam logic [7:0] TYPE_TOUCH_SLEEP = 8'h68;
   localparam logic [7:0] TYPE_STRING      = 8'h70;
   localparam logic [7:0] TYPE_NUMBER      = 8'h71;
   localparam logic [7:0] TYPE_SLEEP       = 8'h86;
   localparam logic [7:0] TYPE_WAKE        = 8'h87;
   localparam logic [7:0] TYPE_LAUNCH      = 8'h88;
   localparam logic [7:0] TYPE_UPGRADE     = 8'h89;

   typedef enum logic [3:0] {
      EV_NONE    = 4'd0,
      EV_ERROR   = 4'd1,
      EV_SUCCESS = 4'd2,
      EV_BUTTON  = 4'd3,
      EV_PAGE    = 4'd4,
      EV_TOUCH   = 4'd5,
      EV_STRING  = 4'd6,
      EV_NUMBER  = 4'd7,
      EV_SLEEP   = 4'd8,
      EV_WAKE    = 4'd9,
      EV_LAUNCH  = 4'd10,
      EV_UPGRADE = 4'd11
   } event_type;

   typedef enum logic [2:0] {
      ERR_COMMAND   = 3'd0,
      ERR_COMPONENT = 3'd1,
      ERR_PAGE      = 3'd2,
      ERR_PICTURE   = 3'd3,
      ERR_FONT      = 3'd4,
      ERR_BAUD      = 3'd5
   } error_type;

   localparam int HEAD_DEPTH = 5;

   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [2:0]  error_code;
      logic [7:0]  page_id;
      logic [7:0]  component_id;
      logic        pressed;
      logic        in_sleep;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [31:0] number_value;
      logic        char_valid;
      logic [7:0]  char_byte;
   } result_type;

endpackage

// ===== hw/rtl/dprf_decode.sv =====
// Frame-end decoder: maps the frame type and the captured bytes to an event.
// Depends on dprf_pkg.
module dprf_decode (
   input  logic [7:0]        frame_type,
   input  dprf_pkg::head_type head_bytes,
   input  logic [31:0]       number_value,
   output logic              event_valid,
   output dprf_pkg::result_type event_fields
);

   always_comb begin
      event_fields = '0;
      event_valid  = 1'b1;
      unique case (frame_type)
         dprf_pkg::TYPE_ERR_CMD: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_COMMAND;
         end
         dprf_pkg::TYPE_ERR_COMP: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_COMPONENT;
         end
         dprf_pkg::TYPE_ERR_PAGE: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_PAGE;
         end
         dprf_pkg::TYPE_ERR_PIC: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_PICTURE;
         end
         dprf_pkg::TYPE_ERR_FONT: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_FONT;
         end
         dprf_pkg::TYPE_ERR_BAUD: begin
            event_fields.event_res  = dprf_pkg::EV_ERROR;
            event_fields.error_code = dprf_pkg::ERR_BAUD;
         end
         dprf_pkg::TYPE_SUCCESS: begin
            event_fields.event_res = dprf_pkg::EV_SUCCESS;
         end
         dprf_pkg::TYPE_BUTTON: begin
            event_fields.event_res    = dprf_pkg::EV_BUTTON;
            event_fields.page_id      = head_bytes[0];
            event_fields.component_id = head_bytes[1];
            event_fields.pressed      = (head_bytes[2] == 8'd1);
         end
         dprf_pkg::TYPE_PAGE: begin
            event_fields.event_res = dprf_pkg::EV_PAGE;
            event_fields.page_id   = head_bytes[0];
         end
         dprf_pkg::TYPE_TOUCH_AWAKE, dprf_pkg::TYPE_TOUCH_SLEEP: begin
            event_fields.event_res = dprf_pkg::EV_TOUCH;
            event_fields.pressed   = (head_bytes[4] == 8'd1);
            event_fields.in_sleep  = (frame_type == dprf_pkg::TYPE_TOUCH_SLEEP);
            event_fields.pos_x     = {head_bytes[0], head_bytes[1]};
            event_fields.pos_y     = {head_bytes[2], head_bytes[3]};
         end
         dprf_pkg::TYPE_STRING: begin
            event_fields.event_res = dprf_pkg::EV_STRING;
         end
         dprf_pkg::TYPE_NUMBER: begin
            event_fields.event_res    = dprf_pkg::EV_NUMBER;
            event_fields.number_value = number_value;
         end
         dprf_pkg::TYPE_SLEEP: begin
            event_fields.event_res = dprf_pkg::EV_SLEEP;
         end
         dprf_pkg::TYPE_WAKE: begin
            event_fields.event_res = dprf_pkg::EV_WAKE;
         end
         dprf_pkg::TYPE_LAUNCH: begin
            event_fields.event_res = dprf_pkg::EV_LAUNCH;
         end
         dprf_pkg::TYPE_UPGRADE: begin
            event_fields.event_res = dprf_pkg::EV_UPGRADE;
         end
         default: begin
            // unknown type: frame ends silently
            event_valid = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/display_reply_frame_parser_core.sv =====
// Top level of the display reply frame parser.
// Depends on dprf_pkg and dprf_decode.
//
// Takes one received display byte per item on the req_ channel and splits
// the byte stream into frames; a frame ends once more than three bytes are
// held and the last three are 0xFF. At the end of a frame the first byte
// (its type) selects the event sent on the rsp_ channel; unknown types end
// silently. Bytes of a string frame stream out as single characters three
// bytes late, stopping at the first zero byte. Each byte is handled in the
// cycle it is accepted: the frame state registers update and any result
// lands in the output register. The block takes one item every cycle; it
// stalls only while a result sits unclaimed in the output register, and
// takes the next item in the same cycle that result is taken.
module display_reply_frame_parser_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] error_code, [10:3] page_id, [18:11] component_id, [19] pressed,
   // [20] in_sleep, [36:21] pos_x, [52:37] pos_y, [84:53] number_value,
   // [92:85] char_byte, [95:93] zero
   output logic [95:0]  rsp_tdata,
   output logic [4:0]   rsp_tuser    // [3:0] event_res, [4] char_valid
);

   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam int TAIL_DEPTH = 6;

   // frame state
   logic [3:0]          count_ff, count_in;
   logic [7:0]          type_ff, type_in;
   dprf_pkg::head_type  head_ff, head_in;
   logic [TAIL_DEPTH-1:0][7:0] tail_ff, tail_in;
   logic                zero_seen_ff, zero_seen_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   dprf_pkg::result_type rsp_ff, rsp_in;

   logic                accept;
   logic [7:0]          rx;
   logic [7:0]          cur_type;
   dprf_pkg::head_type  cur_head;
   logic                char_out;
   logic                char_zero;
   logic                frame_end;
   logic [31:0]         number_value;
   logic                event_valid;
   dprf_pkg::result_type event_fields;

   // hold the output register while a result waits; take input otherwise
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;

   always_comb begin
      // the first byte of a frame is its type; bytes 1..5 are captured
      cur_type = (count_ff == 4'd0) ? rx : type_ff;
      for (int i = 0; i < dprf_pkg::HEAD_DEPTH; i++) begin
         cur_head[i] = (count_ff == 4'(i + 1)) ? rx : head_ff[i];
      end

      // string payload runs three bytes behind the incoming byte
      char_out  = 1'b0;
      char_zero = 1'b0;
      if ((cur_type == dprf_pkg::TYPE_STRING) && (count_ff >= 4'd4) && !zero_seen_ff) begin
         if (tail_ff[2] == 8'd0) begin
            char_zero = 1'b1;
         end else begin
            char_out = 1'b1;
         end
      end

      frame_end = (count_ff >= 4'd3) && (rx == dprf_pkg::END_MARK) &&
                  (tail_ff[0] == dprf_pkg::END_MARK) &&
                  (tail_ff[1] == dprf_pkg::END_MARK);

      // four bytes ahead of the terminator, earliest is least significant
      number_value = {tail_ff[2], tail_ff[3], tail_ff[4], tail_ff[5]};
   end

   dprf_decode u_decode (
      .frame_type   (cur_type),
      .head_bytes   (cur_head),
      .number_value (number_value),
      .event_valid  (event_valid),
      .event_fields (event_fields)
   );

   always_comb begin
      count_in     = count_ff;
      type_in      = type_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      zero_seen_in = zero_seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (accept) begin
         // assemble the result: frame event first, then the streamed character
         rsp_in = '0;
         if (frame_end && event_valid) begin
            rsp_in = event_fields;
         end
         rsp_in.char_valid = char_out;
         rsp_in.char_byte  = char_out ? tail_ff[2] : 8'd0;
         rsp_valid_in      = char_out || (frame_end && event_valid);

         if (frame_end) begin
            // drop the whole frame context
            count_in     = '0;
            type_in      = '0;
            head_in      = '0;
            tail_in      = '0;
            zero_seen_in = 1'b0;
         end else begin
            count_in     = (count_ff < COUNT_MAX) ? count_ff + 4'd1 : COUNT_MAX;
            type_in      = cur_type;
            head_in      = cur_head;
            tail_in      = {tail_ff[TAIL_DEPTH-2:0], rx};
            zero_seen_in = zero_seen_ff || char_zero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         type_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         zero_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         type_ff      <= type_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         zero_seen_ff <= zero_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.char_valid, rsp_ff.event_res};
   assign rsp_tdata  = {3'b000,
                        rsp_ff.char_byte,
                        rsp_ff.number_value,
                        rsp_ff.pos_y,
                        rsp_ff.pos_x,
                        rsp_ff.in_sleep,
                        rsp_ff.pressed,
                        rsp_ff.component_id,
                        rsp_ff.page_id,
                        rsp_ff.error_code};

endmodule
